// ===== sv/clipped_mean_baseline_estimator_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the clipped mean baseline estimator
// ---------------------------------------------------------------------------
`ifndef CLIPPED_MEAN_BASELINE_ESTIMATOR_CORE_MACROS_SVH
`define CLIPPED_MEAN_BASELINE_ESTIMATOR_CORE_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define CMB_ASSERT_IMPL(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define CMB_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/cmbe_pkg.sv =====
// ---------------------------------------------------------------------------
// cmbe_pkg
// Shared types and constants of the clipped mean baseline estimator.
// ---------------------------------------------------------------------------
`default_nettype none
package cmbe_pkg;
   localparam int MAX_HALF_WINDOW = 31;
   localparam int RING      = 2 * MAX_HALF_WINDOW + 1;
   localparam int PTR_W     = 6;
   localparam int SEEN_W    = 7;
   localparam int SEEN_MAX  = 127;
   localparam int BL_W      = 24;
   localparam int SUM_W     = 32;
   localparam int CNT_W     = 6;

   localparam logic [1:0] CSR_HALF_WINDOW   = 2'd0;
   localparam logic [1:0] CSR_REFINE_PASSES = 2'd1;
   localparam logic [1:0] CSR_PAD_VALUE     = 2'd2;

   // One unit of work: an optional baseline position to compute and an optional emit.
   typedef struct packed {
      logic             do_bl;
      logic [5:0]       dq;
      logic             do_em;
      logic [5:0]       dr;
      logic             fin;
      logic             restart;
      logic [PTR_W-1:0] wp;
      logic [SEEN_W-1:0] seen;
   } job_type;
endpackage
`default_nettype wire

// ===== sv/cmbe_divider.sv =====
// ---------------------------------------------------------------------------
// cmbe_divider
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ---------------------------------------------------------------------------
`default_nettype none
module cmbe_divider (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic signed [cmbe_pkg::SUM_W-1:0] dividend,
   input  wire logic [cmbe_pkg::CNT_W:0]         divisor,
   output logic                                 done,
   output logic signed [cmbe_pkg::BL_W-1:0]     quotient
);
   localparam int N = cmbe_pkg::SUM_W;
   logic [N-1:0] rem_ff, rem_in, q_ff, q_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [cmbe_pkg::CNT_W:0] dv_ff, dv_in;
   logic [N:0]   trial;
   logic [N-1:0] qres;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      neg_in = neg_ff; dv_in = dv_ff; done_in = 1'b0;
      trial = '0;
      if (start) begin
         neg_in = dividend[N-1];
         q_in = dividend[N-1] ? (~dividend + 1'b1) : dividend;
         rem_in = '0; dv_in = divisor; cnt_in = 6'(N); busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, q_ff[N-1]} - {{(N+1-cmbe_pkg::CNT_W-1){1'b0}}, dv_ff};
         if (!trial[N]) begin
            rem_in = trial[N-1:0]; q_in = {q_ff[N-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[N-2:0], q_ff[N-1]}; q_in = {q_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; cnt_ff <= cnt_in; neg_ff <= neg_in; dv_ff <= dv_in;
   end

   assign qres = neg_ff ? (~q_ff + 1'b1) : q_ff;
   assign quotient = qres[cmbe_pkg::BL_W-1:0];
   assign done = done_ff;
endmodule
`default_nettype wire

// ===== sv/cmbe_front.sv =====
// ---------------------------------------------------------------------------
// cmbe_front
// Accepts samples, writes the sample ring and issues jobs to the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module cmbe_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [15:0]                req_tdata,
   input  wire logic                       req_tlast,
   input  wire logic [4:0]                 w_eff,
   output logic                            smp_we,
   output logic [cmbe_pkg::PTR_W-1:0]      smp_addr,
   output logic signed [15:0]              smp_data,
   output logic                            job_valid,
   output cmbe_pkg::job_type               job,
   input  wire logic                       job_ready
);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FLUSH = 1'b1;
   logic st_ff, st_in;
   logic [cmbe_pkg::PTR_W-1:0]  wp_ff, wp_in;
   logic [cmbe_pkg::SEEN_W-1:0] seen_ff, seen_in;
   logic [6:0] k_ff, k_in;      // flush step counter
   logic [6:0] top_ff, top_in;
   logic [6:0] w7, seen7;
   logic signed [7:0] dq_s;

   assign w7 = {2'b0, w_eff};
   assign seen7 = seen_ff;
   assign req_tready = (st_ff == ST_IDLE) && job_ready;
   assign smp_we = req_tvalid && req_tready;
   assign smp_addr = wp_ff;
   assign smp_data = $signed(req_tdata);

   always_comb begin
      st_in = st_ff; wp_in = wp_ff; seen_in = seen_ff; k_in = k_ff; top_in = top_ff;
      job_valid = 1'b0; job = '0;
      job.wp = wp_ff; job.seen = seen_ff;
      dq_s = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (smp_we) begin
               if (!req_tlast) begin
                  job.do_bl = (seen7 >= w7);
                  job.dq = w_eff[5-1:0] == 5'd0 ? 6'd0 : {1'b0, w_eff};
                  job.do_em = (seen7 >= {w7[5:0], 1'b0});
                  job.dr = {w_eff, 1'b0};
                  job_valid = job.do_bl || job.do_em;
                  seen_in = (seen_ff == 7'(cmbe_pkg::SEEN_MAX)) ? seen_ff : seen_ff + 7'd1;
                  wp_in = (wp_ff == 6'(cmbe_pkg::RING-1)) ? '0 : wp_ff + 6'd1;
               end else begin
                  st_in = ST_FLUSH; k_in = '0;
                  top_in = (seen7 < w7) ? seen7 : w7;
               end
            end
         end
         ST_FLUSH: begin
            // steps 0..top: baseline at dq=top-k, emit at dq+w; then residual emits
            job_valid = 1'b1; job.fin = 1'b1;
            if (k_ff <= top_ff) begin
               dq_s = $signed({1'b0, top_ff - k_ff});
               job.do_bl = 1'b1; job.dq = dq_s[5:0];
               job.do_em = ({1'b0, top_ff - k_ff} + {1'b0, w7}) <= {1'b0, seen7};
               job.dr = 6'(top_ff - k_ff + w7);
            end else begin
               job.do_bl = 1'b0; job.do_em = 1'b1;
               job.dr = 6'(k_ff - top_ff - 7'd1);
            end
            // residual emits run for dr = min(seen, w-1) .. 0
            if (k_ff > top_ff) begin
               job.dr = 6'(((seen7 < w7) ? seen7 : (w7 - 7'd1)) - (k_ff - top_ff - 7'd1));
            end
            if (job_ready) begin
               k_in = k_ff + 7'd1;
               if ((k_ff > top_ff && job.dr == 6'd0) || (k_ff == top_ff && w7 == 7'd0)) begin
                  job.restart = 1'b1; st_in = ST_IDLE; wp_in = '0; seen_in = '0;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; wp_ff <= '0; seen_ff <= '0; k_ff <= '0; top_ff <= '0;
      end else begin
         st_ff <= st_in; wp_ff <= wp_in; seen_ff <= seen_in; k_ff <= k_in; top_ff <= top_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/cmbe_back.sv =====
// ---------------------------------------------------------------------------
// cmbe_back
// Executes jobs: window sums over the rings, clipped refinement, emission.
// ---------------------------------------------------------------------------
`default_nettype none
module cmbe_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        job_valid,
   input  wire cmbe_pkg::job_type           job,
   output logic                             job_ready,
   input  wire logic                        smp_we,
   input  wire logic [cmbe_pkg::PTR_W-1:0]  smp_addr,
   input  wire logic signed [15:0]          smp_data,
   input  wire logic [4:0]                  w_eff,
   input  wire logic [3:0]                  passes,
   input  wire logic signed [15:0]          pad,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [23:0]                      rsp_data,
   output logic                             rsp_last
);
   localparam logic [2:0] S_IDLE = 3'd0, S_SUM = 3'd1, S_DIV = 3'd2,
                          S_EMIT = 3'd3, S_EDIV = 3'd4, S_OUT = 3'd5;
   localparam int SW = cmbe_pkg::SUM_W;

   logic signed [15:0] smem [cmbe_pkg::RING];
   logic signed [23:0] bmem [cmbe_pkg::RING];
   logic signed [15:0] srd_ff;
   logic signed [23:0] brd_ff;

   logic [2:0] st_ff, st_in;
   cmbe_pkg::job_type j_ff, j_in;
   logic [6:0] t_ff, t_in;           // window index 0..2w, plus read latency
   logic [3:0] pass_ff, pass_in;     // 0 = first mean
   logic signed [SW-1:0] sum_ff, sum_in;
   logic [cmbe_pkg::CNT_W:0] n_ff, n_in;
   logic signed [23:0] bl_ff, bl_in;
   logic vld_ff, vld_in, in_ff, in_in;
   logic [23:0] od_ff, od_in;
   logic ol_ff, ol_in, ov_ff, ov_in;
   logic div_start, div_done, bwe;
   logic signed [SW-1:0] div_a;
   logic [cmbe_pkg::CNT_W:0] div_b;
   logic signed [23:0] div_q;
   logic [6:0] w7, span, d7, base;
   logic [7:0] d8;
   logic [7:0] sl;
   logic [cmbe_pkg::PTR_W-1:0] raddr, baddr;
   logic signed [23:0] sv24, pad24;

   cmbe_divider u_div (.clock, .reset, .start(div_start), .dividend(div_a),
                       .divisor(div_b), .done(div_done), .quotient(div_q));

   assign w7 = {2'b0, w_eff};
   assign span = {w7[5:0], 1'b0};
   assign base = (st_ff == S_EMIT) ? {1'b0, j_ff.dr} : {1'b0, j_ff.dq};
   assign d8 = {1'b0, base} + {1'b0, w7} - {1'b0, t_ff};  // d = base - (t - w)
   assign d7 = d8[6:0];
   assign sl = {2'b0, j_ff.wp} + 8'd126 - {1'b0, d7};
   assign raddr = (sl >= 8'd126) ? 6'(sl - 8'd126) : (sl >= 8'd63) ? 6'(sl - 8'd63) : 6'(sl);
   assign pad24 = {pad, 8'h00};
   assign sv24 = {srd_ff, 8'h00};
   assign baddr = 6'((({2'b0, j_ff.wp} + 8'd63 - {2'b0, j_ff.dq}) >= 8'd63) ?
                     ({2'b0, j_ff.wp} + 8'd63 - {2'b0, j_ff.dq} - 8'd63) :
                     ({2'b0, j_ff.wp} + 8'd63 - {2'b0, j_ff.dq}));

   always_ff @(posedge clock) begin
      if (smp_we) smem[smp_addr] <= smp_data;
      srd_ff <= smem[raddr];
      if (bwe) bmem[baddr] <= bl_in;
      brd_ff <= bmem[raddr];
   end

   assign job_ready = (st_ff == S_IDLE) && !(ov_ff && !rsp_tready);
   assign rsp_tvalid = ov_ff;
   assign rsp_data = od_ff;
   assign rsp_last = ol_ff;

   always_comb begin
      st_in = st_ff; j_in = j_ff; t_in = t_ff; pass_in = pass_ff; sum_in = sum_ff;
      n_in = n_ff; bl_in = bl_ff; vld_in = 1'b0; in_in = 1'b0;
      od_in = od_ff; ol_in = ol_ff; ov_in = ov_ff && !rsp_tready;
      div_start = 1'b0; div_a = sum_ff; div_b = n_ff; bwe = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (job_valid && job_ready) begin
               j_in = job; t_in = '0; pass_in = '0; sum_in = '0; n_in = '0;
               st_in = job.do_bl ? S_SUM : S_EMIT;
            end
         end
         S_SUM, S_EMIT: begin
            // issue reads for t <= span, accumulate the previous read
            vld_in = (t_ff <= span);
            in_in = !d8[7] && (d7 <= j_ff.seen);
            if (vld_ff) begin
               if (st_ff == S_EMIT) begin
                  sum_in = sum_ff + (in_ff ? SW'(brd_ff) : SW'(pad24));
                  n_in = n_ff + 1'b1;
               end else if (pass_ff == 4'd0) begin
                  sum_in = sum_ff + (in_ff ? SW'(sv24) : SW'(pad24));
                  n_in = n_ff + 1'b1;
               end else if (in_ff && sv24 < bl_ff) begin
                  sum_in = sum_ff + SW'(sv24); n_in = n_ff + 1'b1;
               end
            end
            t_in = t_ff + 7'd1;
            if (!vld_ff && t_ff > span) begin
               if (st_ff == S_SUM && pass_ff != 4'd0 && n_ff == '0) begin
                  bwe = 1'b1; bl_in = bl_ff;
                  st_in = j_ff.do_em ? S_EMIT : S_IDLE;
                  t_in = '0; sum_in = '0; n_in = '0;
               end else begin
                  div_start = 1'b1;
                  st_in = (st_ff == S_EMIT) ? S_EDIV : S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               bl_in = div_q; t_in = '0; sum_in = '0; n_in = '0;
               if (pass_ff == passes) begin
                  bwe = 1'b1; st_in = j_ff.do_em ? S_EMIT : S_IDLE;
               end else begin
                  pass_in = pass_ff + 4'd1; st_in = S_SUM;
               end
            end
         end
         S_EDIV: begin
            if (div_done) begin
               od_in = div_q; ol_in = j_ff.fin && (j_ff.dr == 6'd0); st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; vld_ff <= vld_in;
      end
      j_ff <= j_in; t_ff <= t_in; pass_ff <= pass_in; sum_ff <= sum_in; n_ff <= n_in;
      bl_ff <= bl_in; in_ff <= in_in; od_ff <= od_in; ol_ff <= ol_in;
   end
endmodule
`default_nettype wire

// ===== sv/clipped_mean_baseline_estimator_core.sv =====
// ---------------------------------------------------------------------------
// clipped_mean_baseline_estimator_core
// Two-stage clipped moving-average baseline estimator for digitizer traces.
//
// Channel  Direction  tdata / data              tuser / side
// req      in         [15:0] sample             tlast last_sample
// rsp      out        [23:0] baseline_value     tlast last_result
// csr      in         index 2 bits, data 16     -
//
// A job runs at most one window pass and one division for the first mean, for each
// refinement pass and for its emit; the next transfer is taken once the back end is idle.
// The last sample of a trace queues up to 2W+1 further jobs, run one after another.
// Reset is synchronous and clears all control state; the rings are not cleared.
// Either side may stall; a finished result waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "clipped_mean_baseline_estimator_core_macros.svh"
module clipped_mean_baseline_estimator_core #(
   parameter int SAMPLE_BITS     = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [23:0] baseline_value
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   logic [4:0] hw_ff;
   logic [3:0] rp_ff;
   logic signed [15:0] pad_ff;
   logic [4:0] w_eff;
   logic [15:0] smp_ext;
   logic job_valid, job_ready, smp_we;
   cmbe_pkg::job_type job;
   logic [cmbe_pkg::PTR_W-1:0] smp_addr;
   logic signed [15:0] smp_data;

   assign csr_ready = 1'b1;
   assign w_eff = (32'(hw_ff) > cmbe_pkg::MAX_HALF_WINDOW) ?
                  5'(cmbe_pkg::MAX_HALF_WINDOW) : hw_ff;
   assign smp_ext = 16'($signed(req_tdata[SAMPLE_BITS-1:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= 5'd16; rp_ff <= 4'd2; pad_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            cmbe_pkg::CSR_HALF_WINDOW:   hw_ff <= csr_data[4:0];
            cmbe_pkg::CSR_REFINE_PASSES: rp_ff <= csr_data[3:0];
            cmbe_pkg::CSR_PAD_VALUE:     pad_ff <= csr_data;
            default: ;
         endcase
      end
   end

   cmbe_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata(smp_ext), .req_tlast,
      .w_eff, .smp_we, .smp_addr, .smp_data, .job_valid, .job, .job_ready);

   cmbe_back u_back (
      .clock, .reset, .job_valid, .job, .job_ready, .smp_we, .smp_addr, .smp_data,
      .w_eff, .passes(rp_ff), .pad(pad_ff), .rsp_tvalid, .rsp_tready,
      .rsp_data(rsp_tdata), .rsp_last(rsp_tlast));

   `CMB_ASSERT_IMPL(a_no_accept_busy, clock, reset, req_tvalid && req_tready, job_ready)
   `CMB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
endmodule
`default_nettype wire
